@@ rtl/core/stbs_pkg.sv @@
// Shared constants for the sorted table binary search block.
// Request kind codes and fixed payload widths; no dependencies.
package stbs_pkg;

  // Payload widths
  localparam int unsigned DataW = 32;
  localparam int unsigned KindW = 2;
  localparam int unsigned PosW  = 14;

  // Request kinds
  localparam logic [KindW-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KindW-1:0] KIND_LOAD   = 2'd1;
  localparam logic [KindW-1:0] KIND_SEARCH = 2'd2;

endpackage

@@ rtl/core/sorted_table_binary_search_top.sv @@
// Sorted table with binary search: top level.
// Depends on stbs_pkg and stbs_ram.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries kind_i and value_i.
//   A clear request empties the table, a load request appends value_i at
//   the next index (dropped when the table is full), a search request
//   looks for value_i among the loaded entries. Entries are expected to be
//   loaded in ascending signed order without duplicates.
//   Output channel (out_valid_o/out_ready_i) carries found_o and position_o,
//   one response per search; clear and load give none.
// Timing:
//   Clear and load complete in ST_IDLE. A search makes at most
//   ceil(log2(entries+1)) probes; each probe is one registered RAM read
//   (ST_PROBE) followed by one compare (ST_CMP), and the search ends in
//   ST_RESP.
//   The block takes the next request while a response still waits in the
//   output register; a finished search holds until that register is free.
// Reset:
//   rst_ni clears the entry count and the control state. The RAM is not
//   cleared; entries at or above the count are never compared.
module sorted_table_binary_search_top #(
  parameter int unsigned TABLE_DEPTH = 16384
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [stbs_pkg::KindW-1:0]  kind_i,
  input  logic signed [stbs_pkg::DataW-1:0] value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [stbs_pkg::PosW-1:0]   position_o
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;
  localparam logic [1:0] ST_RESP  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  lo_q, lo_d;
  logic [CntW-1:0]  hi_q, hi_d;
  logic [AddrW-1:0] mid_q, mid_d;
  logic signed [stbs_pkg::DataW-1:0] key_q, key_d;
  logic             res_found_q, res_found_d;
  logic [AddrW-1:0] res_pos_q, res_pos_d;

  logic             out_valid_q, out_valid_d;
  logic             found_q, found_d;
  logic [stbs_pkg::PosW-1:0] position_q, position_d;

  logic             in_req;
  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [stbs_pkg::DataW-1:0] ram_rdata;
  logic signed [stbs_pkg::DataW-1:0] probe;
  logic [CntW:0]    mid_sum;
  logic [AddrW-1:0] mid_next;
  logic [stbs_pkg::PosW+AddrW-1:0] pos_ext;
  logic             out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_req     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign probe      = $signed(ram_rdata);

  // Midpoint of the inclusive range [lo, hi-1]; only used when lo < hi
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q} - {{CntW{1'b0}}, 1'b1};
  assign mid_next = mid_sum[AddrW:1];

  // Position is the index masked to the response width
  assign pos_ext = {{stbs_pkg::PosW{1'b0}}, res_pos_q};

  // Table storage: written on load, read on each probe
  assign ram_we   = in_req && (kind_i == stbs_pkg::KIND_LOAD)
                    && (count_q < CntW'(TABLE_DEPTH));
  assign ram_addr = (state_q == ST_IDLE) ? count_q[AddrW-1:0] : mid_next;

  stbs_ram #(
    .Width(stbs_pkg::DataW),
    .Depth(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(value_i),
    .rdata_o(ram_rdata)
  );

  // Request handling and search sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    key_d       = key_q;
    res_found_d = res_found_q;
    res_pos_d   = res_pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    position_d  = position_q;

    case (state_q)
      ST_IDLE: begin
        if (in_req) begin
          case (kind_i)
            stbs_pkg::KIND_CLEAR: begin
              count_d = '0;
            end
            stbs_pkg::KIND_LOAD: begin
              if (ram_we) begin
                count_d = count_q + CntW'(1);
              end
            end
            stbs_pkg::KIND_SEARCH: begin
              lo_d    = '0;
              hi_d    = count_q;
              key_d   = value_i;
              state_d = ST_PROBE;
            end
            default: begin
            end
          endcase
        end
      end
      // Issue the read at the midpoint, or finish on an empty range
      ST_PROBE: begin
        mid_d = mid_next;
        if (lo_q < hi_q) begin
          state_d = ST_CMP;
        end else begin
          res_found_d = 1'b0;
          res_pos_d   = '0;
          state_d     = ST_RESP;
        end
      end
      // Compare the probed entry and narrow the range
      ST_CMP: begin
        if (probe > key_q) begin
          hi_d    = CntW'(mid_q);
          state_d = ST_PROBE;
        end else if (probe < key_q) begin
          lo_d    = CntW'(mid_q) + CntW'(1);
          state_d = ST_PROBE;
        end else begin
          res_found_d = 1'b1;
          res_pos_d   = mid_q;
          state_d     = ST_RESP;
        end
      end
      // Hand the response to the output register once it is free
      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          found_d     = res_found_q;
          position_d  = pos_ext[stbs_pkg::PosW-1:0];
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    key_q       <= key_d;
    res_found_q <= res_found_d;
    res_pos_q   <= res_pos_d;
    found_q     <= found_d;
    position_q  <= position_d;
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign position_o  = position_q;

endmodule

@@ rtl/core/stbs_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module stbs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Read-first; read data in a write cycle is never used by the caller
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Testbench for sorted_table_binary_search_top: table predictor class plus driver tasks.
// Depends on stbs_pkg and the RTL of the block; needs no files or arguments.

typedef struct packed {
  logic                       found;
  logic [stbs_pkg::PosW-1:0]  position;
} search_result_t;

// Mirrors the table and the search, queues the answers of accepted searches
// and checks each response against the oldest one.
class table_search_model #(int unsigned DEPTH = 16384);
  logic signed [stbs_pkg::DataW-1:0] entries [];
  int unsigned                       entry_count;
  search_result_t                    pending_results [$];
  int unsigned                       mismatches;

  function new();
    entries     = new[DEPTH];
    entry_count = 0;
    mismatches  = 0;
  endfunction

  // Binary search over the loaded entries, inclusive midpoint rounded down
  function search_result_t search_entries(logic signed [stbs_pkg::DataW-1:0] key);
    int unsigned    lo;
    int unsigned    hi;
    int unsigned    mid;
    search_result_t res;
    res = '0;
    lo  = 0;
    hi  = entry_count;
    while (lo < hi) begin
      mid = (lo + hi - 1) >> 1;
      if (entries[mid] > key) begin
        hi = mid;
      end else if (entries[mid] < key) begin
        lo = mid + 1;
      end else begin
        res.found    = 1'b1;
        res.position = mid[stbs_pkg::PosW-1:0];
        break;
      end
    end
    return res;
  endfunction

  // Accepted request: update the table or queue a search answer
  function void note_request(logic [stbs_pkg::KindW-1:0] kind,
                             logic signed [stbs_pkg::DataW-1:0] value);
    case (kind)
      stbs_pkg::KIND_CLEAR: begin
        entry_count = 0;
      end
      stbs_pkg::KIND_LOAD: begin
        if (entry_count < DEPTH) begin
          entries[entry_count] = value;
          entry_count++;
        end
      end
      stbs_pkg::KIND_SEARCH: begin
        pending_results = {pending_results, search_entries(value)};
      end
      default: begin
      end
    endcase
  endfunction

  // Accepted response: compare with the oldest pending answer
  function void check_response(logic found, logic [stbs_pkg::PosW-1:0] position);
    search_result_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("response with no search pending: found %0d position %0d", found, position);
      return;
    end
    want = pending_results.pop_front();
    if (found !== want.found || position !== want.position) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: found exp %0d got %0d, position exp %0d got %0d",
                 want.found, found, want.position, position);
    end
  endfunction

  function int unsigned pending();
    return pending_results.size();
  endfunction
endclass

module tb;

  localparam int unsigned TABLE_DEPTH    = 16384;
  localparam int unsigned DRAIN_CYCLES   = 48;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_REQUESTS = 350;
  localparam logic [stbs_pkg::KindW-1:0] KIND_UNUSED = 2'd3;

  logic                              clk_i;
  logic                              rst_ni      = 1'b0;
  logic                              in_valid_i  = 1'b0;
  logic                              in_ready_o;
  logic [stbs_pkg::KindW-1:0]        kind_i      = stbs_pkg::KIND_CLEAR;
  logic signed [stbs_pkg::DataW-1:0] value_i     = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic                              found_o;
  logic [stbs_pkg::PosW-1:0]         position_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned requests_sent  = 0;
  int unsigned quiet_cycles   = 0;

  table_search_model #(TABLE_DEPTH) sb;

  sorted_table_binary_search_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .found_o    (found_o),
    .position_o (position_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Response side backpressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Sample both handshakes at the edge; track cycles without progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(kind_i, value_i);
      if (out_valid_o && out_ready_i) sb.check_response(found_o, position_o);
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("[sorted_table_binary_search_top] ERROR");
    $finish;
  end

  // One request, with a random idle gap in front of it
  task automatic send_request(input logic [stbs_pkg::KindW-1:0] kind,
                              input logic signed [stbs_pkg::DataW-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    if (kind != KIND_UNUSED) requests_sent++;
  endtask

  // Stop sending, wait for every answer, then let the block settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_directed();
    // empty table, unused kind
    send_request(stbs_pkg::KIND_SEARCH, 32'sd0);
    send_request(KIND_UNUSED, -32'sd1);
    // value extremes, loaded ascending
    send_request(stbs_pkg::KIND_LOAD, 32'sh8000_0000);
    send_request(stbs_pkg::KIND_LOAD, -32'sd1);
    send_request(stbs_pkg::KIND_LOAD, 32'sd0);
    send_request(stbs_pkg::KIND_LOAD, 32'sd1);
    send_request(stbs_pkg::KIND_LOAD, 32'sh7fff_ffff);
    send_request(stbs_pkg::KIND_SEARCH, 32'sh8000_0000);
    send_request(stbs_pkg::KIND_SEARCH, -32'sd1);
    send_request(stbs_pkg::KIND_SEARCH, 32'sd0);
    send_request(stbs_pkg::KIND_SEARCH, 32'sd1);
    send_request(stbs_pkg::KIND_SEARCH, 32'sh7fff_ffff);
    // absent keys
    send_request(stbs_pkg::KIND_SEARCH, 32'sd5);
    send_request(stbs_pkg::KIND_SEARCH, -32'sd2);
    // unused kind must not append
    send_request(KIND_UNUSED, 32'sh7fff_ffff);
    send_request(stbs_pkg::KIND_SEARCH, 32'sh7fff_ffff);
    // clear keeps old contents out of reach
    send_request(stbs_pkg::KIND_CLEAR, 32'sd0);
    send_request(stbs_pkg::KIND_SEARCH, 32'sd0);
    // unsorted loads follow the probe sequence
    send_request(stbs_pkg::KIND_LOAD, 32'sd7);
    send_request(stbs_pkg::KIND_LOAD, 32'sd9);
    send_request(stbs_pkg::KIND_LOAD, 32'sd3);
    send_request(stbs_pkg::KIND_SEARCH, 32'sd3);
    send_request(stbs_pkg::KIND_SEARCH, 32'sd9);
    send_request(stbs_pkg::KIND_SEARCH, 32'sd7);
    send_request(stbs_pkg::KIND_CLEAR, -32'sd1);
  endtask

  // Mostly clear + sorted loads + searches; the rest is noise
  task automatic run_random(input int unsigned target);
    int unsigned start;
    int unsigned n;
    int unsigned nsearch;
    int unsigned roll;
    int          vals [$];
    int          tmp [$];
    longint      base;
    int          key;
    start = requests_sent;
    while (requests_sent - start < target) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        vals.delete();
        tmp.delete();
        n = ($urandom_range(9) == 0) ? $urandom_range(64, 400) : $urandom_range(0, 24);
        if ($urandom_range(1) == 1) begin
          // spread over the whole range
          for (int i = 0; i < n; i++) tmp = {tmp, int'($urandom)};
          tmp.sort();
          foreach (tmp[i]) if (vals.size() == 0 || vals[$] != tmp[i]) vals = {vals, tmp[i]};
        end else begin
          // dense run, so neighbors of entries are often absent
          base = longint'(int'($urandom));
          if ($urandom_range(7) == 0) base = -64'sd2147483649;
          if (base > 64'sd2147483647 - 4 * longint'(n)) begin
            base = 64'sd2147483647 - 4 * longint'(n);
          end
          for (int i = 0; i < n; i++) begin
            base += $urandom_range(1, 3);
            vals = {vals, int'(base)};
          end
        end
        send_request(stbs_pkg::KIND_CLEAR, int'($urandom));
        foreach (vals[i]) send_request(stbs_pkg::KIND_LOAD, vals[i]);
        nsearch = $urandom_range(1, 12);
        for (int i = 0; i < nsearch; i++) begin
          roll = $urandom_range(99);
          if (vals.size() == 0 || roll >= 85) begin
            key = int'($urandom);
          end else begin
            key = vals[$urandom_range(vals.size() - 1)];
            if (roll >= 60) key = ($urandom_range(1) == 1) ? key + 1 : key - 1;
          end
          send_request(stbs_pkg::KIND_SEARCH, key);
        end
      end else if (roll < 80) begin
        // appends in no particular order
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) send_request(stbs_pkg::KIND_LOAD, int'($urandom));
      end else if (roll < 90) begin
        send_request(KIND_UNUSED, int'($urandom));
      end else begin
        send_request(stbs_pkg::KIND_SEARCH, int'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    wait_drained();

    // idle and stall profiles
    send_idle_pct = 0;  recv_stall_pct = 0;
    run_random(PHASE_REQUESTS);
    wait_drained();
    send_idle_pct = 76; recv_stall_pct = 0;
    run_random(PHASE_REQUESTS);
    wait_drained();
    send_idle_pct = 0;  recv_stall_pct = 76;
    run_random(PHASE_REQUESTS);
    wait_drained();
    send_idle_pct = 15; recv_stall_pct = 15;
    run_random(PHASE_REQUESTS);
    wait_drained();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[sorted_table_binary_search_top] OK");
    end else begin
      $display("[sorted_table_binary_search_top] ERROR");
    end
    $finish;
  end

endmodule
